@@ rtl/core/pft_pkg.sv @@
// ----------------------------------------------------------------------------
// pft_pkg
// Shared widths, constants, arctangent table and types of the planar frame
// transform core.
// ----------------------------------------------------------------------------
package pft_pkg;

    // item field widths
    localparam int COORD_W    = 24;
    localparam int ANGLE_W    = 16;
    localparam int ROT_STAGES = 16;

    // fixed cordic arithmetic
    localparam int PHASE_W   = 32;
    localparam int GUARD     = 8;
    localparam int GAIN_FRAC = 30;
    localparam int GAIN_SH   = GAIN_FRAC + GUARD - 32;
    localparam logic [GAIN_FRAC-1:0] GAIN_K = 30'd652032874;

    // datapath widths
    localparam int DIFF_W  = COORD_W + 1;
    localparam int XW      = COORD_W + GUARD + 4;
    localparam int MAG_W   = (XW > 32) ? XW : 33;
    localparam int HI_W    = MAG_W - 32;
    localparam int T_W     = HI_W + GAIN_FRAC + 1;
    localparam int RV_W    = T_W - GAIN_SH + 1;
    localparam int SUM_W   = RV_W + 1;
    localparam int SHIFT_W = (ROT_STAGES > 1) ? $clog2(ROT_STAGES) : 1;

    // cycles from an accepted item to its result strobe
    localparam int LATENCY = ROT_STAGES + 5;

    // atan(2^-i) in 2^32-per-turn units
    localparam logic [PHASE_W-1:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // operation codes
    typedef enum logic [1:0] {
        OP_G2R = 2'd0,
        OP_R2G = 2'd1,
        OP_ROT = 2'd2
    } pft_op_t;

    // vector and residual angle moving down the rotation chain
    typedef struct packed {
        logic signed [XW-1:0]      x;
        logic signed [XW-1:0]      y;
        logic signed [PHASE_W-1:0] z;
    } pft_vec_t;

    // origin carried alongside for the final add
    typedef struct packed {
        logic                      add_org;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
    } pft_side_t;

endpackage

@@ rtl/core/pft_prep.sv @@
// ----------------------------------------------------------------------------
// pft_prep
// Input stage: origin subtract, phase alignment and negation, coarse
// half-turn fold, guard bit alignment.
// ----------------------------------------------------------------------------
module pft_prep (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [1:0]                        op,
    input  logic signed [pft_pkg::COORD_W-1:0] point_x,
    input  logic signed [pft_pkg::COORD_W-1:0] point_y,
    input  logic signed [pft_pkg::COORD_W-1:0] origin_x,
    input  logic signed [pft_pkg::COORD_W-1:0] origin_y,
    input  logic signed [pft_pkg::ANGLE_W-1:0] angle,
    output logic                              valid,
    output pft_pkg::pft_vec_t                 vec,
    output pft_pkg::pft_side_t                side
);
    import pft_pkg::*;

    logic                      valid_reg;
    pft_vec_t                  vec_reg;
    pft_vec_t                  vec_next;
    pft_side_t                 side_reg;
    pft_side_t                 side_next;
    logic                      g2r;
    logic signed [DIFF_W-1:0]  vx;
    logic signed [DIFF_W-1:0]  vy;
    logic [PHASE_W-1:0]        phase_raw;
    logic [PHASE_W-1:0]        phase;
    logic signed [XW-1:0]      ax;
    logic signed [XW-1:0]      ay;
    logic                      fold;

    // op decode
    always_comb
    begin
        g2r           = 1'b0;
        side_next.add_org = 1'b0;
        unique case (op)
            OP_G2R:  g2r = 1'b1;
            OP_R2G:  side_next.add_org = 1'b1;
            default: g2r = 1'b0;
        endcase
        side_next.ox = origin_x;
        side_next.oy = origin_y;
    end

    // vector select, phase alignment and coarse fold
    always_comb
    begin
        vx = DIFF_W'(point_x);
        vy = DIFF_W'(point_y);
        if (g2r)
        begin
            vx = DIFF_W'(point_x) - DIFF_W'(origin_x);
            vy = DIFF_W'(point_y) - DIFF_W'(origin_y);
        end
        phase_raw = PHASE_W'($unsigned(angle)) << (PHASE_W - ANGLE_W);
        phase     = g2r ? (PHASE_W'(0) - phase_raw) : phase_raw;
        ax        = XW'(vx) <<< GUARD;
        ay        = XW'(vy) <<< GUARD;
        fold      = phase[PHASE_W-1] ^ phase[PHASE_W-2];
        vec_next.x = fold ? -ax : ax;
        vec_next.y = fold ? -ay : ay;
        vec_next.z = $signed({phase[PHASE_W-1] ^ fold, phase[PHASE_W-2:0]});
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        vec_reg  <= vec_next;
        side_reg <= side_next;
    end

    assign valid = valid_reg;
    assign vec   = vec_reg;
    assign side  = side_reg;

endmodule

@@ rtl/core/pft_cell.sv @@
// ----------------------------------------------------------------------------
// pft_cell
// One cordic micro-rotation: shift-add on the vector, residual angle update,
// origin passed along to the next cell.
// ----------------------------------------------------------------------------
module pft_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [pft_pkg::SHIFT_W-1:0]    shamt,
    input  logic [pft_pkg::PHASE_W-1:0]    atan,
    input  logic                           in_valid,
    input  pft_pkg::pft_vec_t              in_vec,
    input  pft_pkg::pft_side_t             in_side,
    output logic                           out_valid,
    output pft_pkg::pft_vec_t              out_vec,
    output pft_pkg::pft_side_t             out_side
);
    import pft_pkg::*;

    logic                  valid_reg;
    pft_vec_t              vec_reg;
    pft_vec_t              vec_next;
    pft_side_t             side_reg;
    logic signed [XW-1:0]  dx;
    logic signed [XW-1:0]  dy;

    // rotate toward zero residual angle, cross terms from the old vector
    always_comb
    begin
        dx = in_vec.y >>> shamt;
        dy = in_vec.x >>> shamt;
        if (!in_vec.z[PHASE_W-1])
        begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - $signed(atan);
        end
        else
        begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + $signed(atan);
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        vec_reg  <= vec_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/core/pft_gain.sv @@
// ----------------------------------------------------------------------------
// pft_gain
// Output stages: magnitude split, gain multiply in two partial products,
// rounding, origin add and saturation.
// ----------------------------------------------------------------------------
module pft_gain (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  pft_pkg::pft_vec_t                  in_vec,
    input  pft_pkg::pft_side_t                 in_side,
    output logic                               done,
    output logic signed [pft_pkg::COORD_W-1:0] result_x,
    output logic signed [pft_pkg::COORD_W-1:0] result_y,
    output logic                               saturated
);
    import pft_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    logic [3:0]                       valid_reg;
    pft_side_t                        side1_reg;
    pft_side_t                        side2_reg;
    pft_side_t                        side3_reg;
    logic                             neg1_reg [2];
    logic                             neg2_reg [2];
    logic [MAG_W-1:0]                 mag_reg  [2];
    logic [MAG_W-1:0]                 mag_next [2];
    logic [GAIN_FRAC+31:0]            plo_reg  [2];
    logic [HI_W+GAIN_FRAC-1:0]        phi_reg  [2];
    logic signed [RV_W-1:0]           val_reg  [2];
    logic signed [RV_W-1:0]           val_next [2];
    logic signed [COORD_W-1:0]        res_reg  [2];
    logic signed [COORD_W-1:0]        res_next [2];
    logic                             sat_reg;
    logic                             sat_next;
    logic signed [XW-1:0]             coord    [2];
    logic signed [XW-1:0]             absv     [2];
    logic [T_W-1:0]                   tsum     [2];
    logic [T_W-1:0]                   trnd     [2];
    logic signed [RV_W-1:0]           tmag     [2];
    logic signed [SUM_W-1:0]          sum      [2];
    logic signed [COORD_W-1:0]        org      [2];

    // magnitude of each coordinate
    always_comb
    begin
        coord[0] = in_vec.x;
        coord[1] = in_vec.y;
        for (int k = 0; k < 2; k++)
        begin
            absv[k]     = coord[k][XW-1] ? -coord[k] : coord[k];
            mag_next[k] = MAG_W'($unsigned(absv[k]));
        end
    end

    // rounded scaled magnitude, sign restored
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            tsum[k]     = T_W'(phi_reg[k]) + T_W'(plo_reg[k] >> 32);
            trnd[k]     = (tsum[k] + (T_W'(1) << (GAIN_SH - 1))) >> GAIN_SH;
            tmag[k]     = $signed({1'b0, trnd[k][RV_W-2:0]});
            val_next[k] = neg2_reg[k] ? -tmag[k] : tmag[k];
        end
    end

    // origin add and clip
    always_comb
    begin
        org[0]   = side3_reg.ox;
        org[1]   = side3_reg.oy;
        sat_next = 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            sum[k] = SUM_W'(val_reg[k]);
            if (side3_reg.add_org)
            begin
                sum[k] = SUM_W'(val_reg[k]) + SUM_W'(org[k]);
            end
            res_next[k] = sum[k][COORD_W-1:0];
            if (sum[k] > SAT_MAX)
            begin
                res_next[k] = SAT_MAX[COORD_W-1:0];
                sat_next    = 1'b1;
            end
            else if (sum[k] < SAT_MIN)
            begin
                res_next[k] = SAT_MIN[COORD_W-1:0];
                sat_next    = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        side1_reg <= in_side;
        side2_reg <= side1_reg;
        side3_reg <= side2_reg;
        for (int k = 0; k < 2; k++)
        begin
            neg1_reg[k] <= coord[k][XW-1];
            mag_reg[k]  <= mag_next[k];
            neg2_reg[k] <= neg1_reg[k];
            plo_reg[k]  <= mag_reg[k][31:0] * GAIN_K;
            phi_reg[k]  <= mag_reg[k][MAG_W-1:32] * GAIN_K;
            val_reg[k]  <= val_next[k];
            res_reg[k]  <= res_next[k];
        end
        sat_reg <= sat_next;
    end

    assign done      = valid_reg[3];
    assign result_x  = res_reg[0];
    assign result_y  = res_reg[1];
    assign saturated = sat_reg;

endmodule

@@ rtl/core/planar_frame_transform_core.sv @@
// ----------------------------------------------------------------------------
// planar_frame_transform_core
// 2d frame transform (global to relative, relative to global, rotate only)
// on a pipelined gain-corrected cordic with saturating outputs.
// ----------------------------------------------------------------------------
//  channel  | handshake       | payload
//  ---------+-----------------+-------------------------------------------------
//  command  | start / busy    | op, point_x, point_y, origin_x, origin_y, angle
//  result   | done (strobe)   | result_x, result_y, saturated
//
//  one item per cycle; an accepted item passes one input stage, one rotation
//  cell per stage and four output stages for the split gain multiply,
//  rounding and clipping before its result strobes.
//  busy is high only while reset is asserted; reset empties the pipeline.
//  the result channel has no back pressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module planar_frame_transform_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         op,
    input  logic signed [pft_pkg::COORD_W-1:0] point_x,
    input  logic signed [pft_pkg::COORD_W-1:0] point_y,
    input  logic signed [pft_pkg::COORD_W-1:0] origin_x,
    input  logic signed [pft_pkg::COORD_W-1:0] origin_y,
    input  logic signed [pft_pkg::ANGLE_W-1:0] angle,
    output logic                               done,
    output logic signed [pft_pkg::COORD_W-1:0] result_x,
    output logic signed [pft_pkg::COORD_W-1:0] result_y,
    output logic                               saturated
);
    import pft_pkg::*;

    logic       accept;
    logic       chain_valid [ROT_STAGES+1];
    pft_vec_t   chain_vec   [ROT_STAGES+1];
    pft_side_t  chain_side  [ROT_STAGES+1];

    assign busy   = !rst_n;
    assign accept = start && !busy;

    // input stage
    pft_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .op       (op),
        .point_x  (point_x),
        .point_y  (point_y),
        .origin_x (origin_x),
        .origin_y (origin_y),
        .angle    (angle),
        .valid    (chain_valid[0]),
        .vec      (chain_vec[0]),
        .side     (chain_side[0])
    );

    // rotation cells
    for (genvar i = 0; i < ROT_STAGES; i++)
    begin : g_cell
        pft_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shamt     (SHIFT_W'(i)),
            .atan      (ATAN_TAB[i]),
            .in_valid  (chain_valid[i]),
            .in_vec    (chain_vec[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_vec   (chain_vec[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    // gain correction and output
    pft_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[ROT_STAGES]),
        .in_vec    (chain_vec[ROT_STAGES]),
        .in_side   (chain_side[ROT_STAGES]),
        .done      (done),
        .result_x  (result_x),
        .result_y  (result_y),
        .saturated (saturated)
    );

    // every accepted item strobes a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result strobe missing after accepted item");

    // no result without an item accepted the latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without accepted item");

    // saturation flag only with a coordinate at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
            (result_x == {1'b0, {(COORD_W-1){1'b1}}} ||
             result_x == {1'b1, {(COORD_W-1){1'b0}}} ||
             result_y == {1'b0, {(COORD_W-1){1'b1}}} ||
             result_y == {1'b1, {(COORD_W-1){1'b0}}}))
        else $error("saturated set with both coordinates in range");

    // rotating the zero vector gives zero
    a_zero_rot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_ROT && point_x == '0 && point_y == '0) |->
            ##LATENCY (done && result_x == '0 && result_y == '0 && !saturated))
        else $error("zero vector rotation not zero");

endmodule

@@ tb/sv/pft_frame_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_frame_check_pkg
// Expected-result store and bit-exact predictor for the planar frame
// transform core: origin offset, binary-angle cordic rotation, gain
// correction with rounding, origin add and output clipping.
// ----------------------------------------------------------------------------
package pft_frame_check_pkg;

    import pft_pkg::*;

    // op code that the package enum leaves out; the core treats it as rotate only
    localparam logic [1:0] OP_SPARE = 2'd3;

    // arctangent of 2^-i, one turn is 2^32
    localparam longint ARC_STEP [32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
        64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051,
        64'h00000028, 64'h00000014, 64'h0000000A, 64'h00000005,
        64'h00000002, 64'h00000001, 64'h00000000, 64'h00000000
    };

    // inverse cordic gain with 30 fraction bits, 8 guard bits on the vector
    localparam longint unsigned INV_GAIN   = 64'd652032874;
    localparam int              VEC_GUARD  = 8;
    localparam int              GAIN_DROP  = 30 + VEC_GUARD - 32;
    localparam longint          COORD_HI   = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint          COORD_LO   = -(64'sd1 <<< (COORD_W - 1));

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      sat;
    } frame_xy_t;

    class frame_scoreboard;

        frame_xy_t   expected_q[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // multiply by the inverse gain, drop the fraction, round half away
        function automatic longint gain_scale(longint v);
            longint unsigned mag;
            longint unsigned prod;
            mag  = (v < 0) ? -v : v;
            prod = (mag >> 32) * INV_GAIN + (((mag & 64'hFFFF_FFFF) * INV_GAIN) >> 32);
            prod = (prod + (64'd1 << (GAIN_DROP - 1))) >> GAIN_DROP;
            return (v < 0) ? -longint'(prod) : longint'(prod);
        endfunction

        // full transform of one item
        function automatic frame_xy_t transform(logic [1:0] c_op,
                                                logic signed [COORD_W-1:0] px,
                                                logic signed [COORD_W-1:0] py,
                                                logic signed [COORD_W-1:0] ox,
                                                logic signed [COORD_W-1:0] oy,
                                                logic signed [ANGLE_W-1:0] ang);
            longint      vx;
            longint      vy;
            longint      z;
            longint      dx;
            longint      dy;
            logic [31:0] phase;
            frame_xy_t   res;
            vx    = px;
            vy    = py;
            phase = {ang, {(32 - ANGLE_W){1'b0}}};
            if (c_op == OP_G2R)
            begin
                vx    = vx - longint'(ox);
                vy    = vy - longint'(oy);
                phase = 32'd0 - phase;
            end
            vx = vx * (64'sd1 <<< VEC_GUARD);
            vy = vy * (64'sd1 <<< VEC_GUARD);

            // fold the second and third quarter turns onto the other half
            if (phase[31] != phase[30])
            begin
                vx    = -vx;
                vy    = -vy;
                phase = phase + 32'h8000_0000;
            end
            z = longint'($signed(phase));

            // micro-rotations
            for (int i = 0; i < ROT_STAGES && i < 32; i++)
            begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (z >= 0)
                begin
                    vx = vx - dx;
                    vy = vy + dy;
                    z  = z - ARC_STEP[i];
                end
                else
                begin
                    vx = vx + dx;
                    vy = vy - dy;
                    z  = z + ARC_STEP[i];
                end
            end
            vx = gain_scale(vx);
            vy = gain_scale(vy);
            if (c_op == OP_R2G)
            begin
                vx = vx + longint'(ox);
                vy = vy + longint'(oy);
            end

            // clip each coordinate and flag it
            res.sat = 1'b0;
            if (vx > COORD_HI)
            begin
                vx      = COORD_HI;
                res.sat = 1'b1;
            end
            else if (vx < COORD_LO)
            begin
                vx      = COORD_LO;
                res.sat = 1'b1;
            end
            if (vy > COORD_HI)
            begin
                vy      = COORD_HI;
                res.sat = 1'b1;
            end
            else if (vy < COORD_LO)
            begin
                vy      = COORD_LO;
                res.sat = 1'b1;
            end
            res.x = vx[COORD_W-1:0];
            res.y = vy[COORD_W-1:0];
            return res;
        endfunction

        // accepted item: queue its transform
        function void note_item(logic [1:0] c_op,
                                logic signed [COORD_W-1:0] px,
                                logic signed [COORD_W-1:0] py,
                                logic signed [COORD_W-1:0] ox,
                                logic signed [COORD_W-1:0] oy,
                                logic signed [ANGLE_W-1:0] ang);
            expected_q.push_back(transform(c_op, px, py, ox, oy, ang));
        endfunction

        // strobed result against the oldest transform
        function void check_result(logic signed [COORD_W-1:0] rx,
                                   logic signed [COORD_W-1:0] ry,
                                   logic                      rsat);
            frame_xy_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing pending: x=%0d y=%0d saturated=%0b",
                       rx, ry, rsat);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (rx !== want.x)
            begin
                $error("result_x: expected %0d, got %0d", want.x, rx);
                errors++;
            end
            if (ry !== want.y)
            begin
                $error("result_y: expected %0d, got %0d", want.y, ry);
                errors++;
            end
            if (rsat !== want.sat)
            begin
                $error("saturated: expected %0b, got %0b", want.sat, rsat);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

@@ tb/sv/planar_frame_transform_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_frame_transform_core_tb
// Drives directed corner items (range extremes, every op including the spare
// code, half-turn angles, clipping) and then about twelve hundred random
// items with random input gaps, and checks every strobed result against a
// bit-exact transform kept in a scoreboard.
// ----------------------------------------------------------------------------
module planar_frame_transform_core_tb;

    import pft_pkg::*;
    import pft_frame_check_pkg::*;

    localparam logic signed [COORD_W-1:0] C_MAX   = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN   = {1'b1, {(COORD_W - 1){1'b0}}};
    localparam logic signed [ANGLE_W-1:0] A_MAX   = {1'b0, {(ANGLE_W - 1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] A_MIN   = {1'b1, {(ANGLE_W - 1){1'b0}}};
    localparam logic signed [ANGLE_W-1:0] A_QTR   = ANGLE_W'(1 << (ANGLE_W - 2));
    localparam logic signed [ANGLE_W-1:0] A_EIGHT = ANGLE_W'(1 << (ANGLE_W - 3));
    localparam int RANDOM_ITEMS = 1230;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                op;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [ANGLE_W-1:0] angle;
    logic                      done;
    logic signed [COORD_W-1:0] result_x;
    logic signed [COORD_W-1:0] result_y;
    logic                      saturated;

    frame_scoreboard sb = new();
    bit              gaps_on;

    planar_frame_transform_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .point_x   (point_x),
        .point_y   (point_y),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .angle     (angle),
        .done      (done),
        .result_x  (result_x),
        .result_y  (result_y),
        .saturated (saturated)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("planar_frame_transform_core_tb: done, errors");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result_x, result_y, saturated);
    end

    // one item: optional gap, then hold start until accepted
    task automatic send_item(input logic [1:0]                c_op,
                             input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic signed [COORD_W-1:0] ox,
                             input logic signed [COORD_W-1:0] oy,
                             input logic signed [ANGLE_W-1:0] ang);
        while (gaps_on && $urandom_range(0, 99) < 18)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        op       <= c_op;
        point_x  <= px;
        point_y  <= py;
        origin_x <= ox;
        origin_y <= oy;
        angle    <= ang;
        @(posedge clk);
        while (busy)
        begin
            @(negedge clk);
            @(posedge clk);
        end
        sb.note_item(c_op, px, py, ox, oy, ang);
        @(negedge clk);
    endtask

    // hold off until every pending result has come
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // coordinates: mostly full range, some small, some at the extremes
    function automatic logic signed [COORD_W-1:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return COORD_W'($urandom);
        else if (pick < 85)
            return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
        else if (pick < 93)
            return C_MAX;
        else
            return C_MIN;
    endfunction

    // angles: mostly uniform, some quarter-turn and wrap points
    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        if ($urandom_range(0, 99) < 75)
            return ANGLE_W'($urandom);
        case ($urandom_range(0, 6))
            0: return '0;
            1: return A_MIN;
            2: return A_MAX;
            3: return A_QTR;
            4: return -A_QTR;
            5: return A_EIGHT;
            default: return A_MIN + 1'b1;
        endcase
    endfunction

    // stimulus
    initial
    begin
        logic [1:0]  r_op;
        int unsigned pick;
        rst_n    = 1'b0;
        start    = 1'b0;
        op       = OP_G2R;
        point_x  = '0;
        point_y  = '0;
        origin_x = '0;
        origin_y = '0;
        angle    = '0;
        gaps_on  = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners
        send_item(OP_G2R, 0, 0, 0, 0, 0);
        send_item(OP_R2G, 1000, -2000, 300, 400, 0);
        send_item(OP_ROT, 256, 0, 0, 0, A_QTR);
        send_item(OP_ROT, 256, 0, 0, 0, -A_QTR);
        send_item(OP_ROT, 256, 512, 0, 0, A_MIN);
        send_item(OP_G2R, 256, 512, 0, 0, A_MIN);
        send_item(OP_R2G, -700, 900, 5, 5, A_MIN);
        send_item(OP_ROT, C_MAX, C_MAX, 0, 0, A_EIGHT);
        send_item(OP_ROT, C_MIN, C_MIN, 0, 0, 0);
        send_item(OP_ROT, C_MAX, C_MIN, 0, 0, A_MAX);
        send_item(OP_G2R, C_MAX, C_MAX, C_MIN, C_MIN, 0);
        send_item(OP_G2R, C_MIN, C_MIN, C_MAX, C_MAX, A_QTR);
        send_item(OP_R2G, C_MAX, C_MIN, C_MAX, C_MIN, 0);
        send_item(OP_R2G, 0, 0, C_MIN, C_MAX, A_MAX);
        send_item(OP_SPARE, 4096, -4096, 77, 88, A_EIGHT);
        send_item(OP_SPARE, C_MIN, C_MAX, C_MAX, C_MIN, A_MIN);
        send_item(OP_ROT, 1, -1, C_MAX, C_MIN, 1);
        send_item(OP_G2R, 12345, -54321, -1000, 2000, -1);
        send_item(OP_R2G, -1, -1, -1, -1, A_MIN + 1'b1);
        send_item(OP_ROT, C_MAX, 0, 0, 0, A_QTR);
        drain();

        // random items, with one gap-free stretch and one full drain
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= 300 && n < 650);
            if (n == 800)
                drain();
            pick = $urandom_range(0, 15);
            if (pick < 5)
                r_op = OP_G2R;
            else if (pick < 10)
                r_op = OP_R2G;
            else if (pick < 15)
                r_op = OP_ROT;
            else
                r_op = OP_SPARE;
            send_item(r_op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_angle());
        end
        start <= 1'b0;

        // let the pipeline empty, then watch for stray strobes
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("planar_frame_transform_core_tb: done, clean");
        else
            $display("planar_frame_transform_core_tb: done, errors");
        $finish;
    end

endmodule
